// ===== hdl/m64kh_pkg.sv =====
// Shared types and constants for the 64-bit key hash engine.
`timescale 1ns / 1ps

package m64kh_pkg;

	localparam logic [63:0] GOLDEN_RATIO = 64'h9e3779b97f4a7c13;
	localparam logic [4:0]  MAX_TAIL     = 5'd23;
	localparam logic [63:0] BLOCK_BYTES  = 64'd24;
	localparam int          MIX_ROUNDS   = 12;

	// Shift amount of each mix line, in order
	localparam logic [5:0] MIX_SHIFT [0:MIX_ROUNDS-1] = '{
		6'd43, 6'd9,  6'd8,
		6'd38, 6'd23, 6'd5,
		6'd35, 6'd49, 6'd11,
		6'd12, 6'd18, 6'd22
	};

	// Which accumulator a mix line updates
	typedef enum logic [1:0] {
		LANE_A,
		LANE_B,
		LANE_C
	} lane_t;

	// Back end sequencer states
	typedef enum logic {
		BK_IDLE,
		BK_MIX
	} back_state_t;

	// Classified item handed from front to back
	typedef struct packed {
		logic [63:0] word_a;
		logic [63:0] word_b;
		logic [63:0] word_c;   // already masked and shifted on a last item
		logic [63:0] seed;
		logic [63:0] length;   // total key length, zero unless last
		logic        first;
		logic        last;
	} hash_entry_t;

	// Keep the low n bytes of a word; n of 8 or more keeps all
	function automatic logic [63:0] low_bytes(input logic [63:0] w, input logic [4:0] n);
		logic [63:0] m;
		m = '0;
		for (int i = 0; i < 8; i++) begin
			if (5'(i) < n) begin
				m[i*8 +: 8] = 8'hff;
			end
		end
		return w & m;
	endfunction

endpackage

// ===== hdl/m64kh_front.sv =====
// Front end: tracks key boundaries and length, masks tail bytes.
`timescale 1ns / 1ps

module m64kh_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 accept,
	input  logic [63:0]          word_a,
	input  logic [63:0]          word_b,
	input  logic [63:0]          word_c,
	input  logic [4:0]           tail_bytes,
	input  logic                 last,
	input  logic [63:0]          seed,
	output m64kh_pkg::hash_entry_t entry
);

	logic        mid_key_q;
	logic [63:0] count_q;
	logic [63:0] base_count;
	logic [4:0]  tail_n;
	logic [4:0]  nb;
	logic [4:0]  nc;

	// Byte counts per word of the tail
	always_comb begin
		tail_n = (tail_bytes > m64kh_pkg::MAX_TAIL) ? m64kh_pkg::MAX_TAIL : tail_bytes;
		nb     = (tail_n > 5'd8)  ? tail_n - 5'd8  : 5'd0;
		nc     = (tail_n > 5'd16) ? tail_n - 5'd16 : 5'd0;
		base_count = mid_key_q ? count_q : 64'd0;
	end

	// Build the queue entry
	always_comb begin
		entry.seed  = seed;
		entry.first = !mid_key_q;
		entry.last  = last;
		if (last) begin
			entry.word_a = m64kh_pkg::low_bytes(word_a, tail_n);
			entry.word_b = m64kh_pkg::low_bytes(word_b, nb);
			entry.word_c = m64kh_pkg::low_bytes(word_c, nc) << 8;
			entry.length = base_count + {59'd0, tail_n};
		end else begin
			entry.word_a = word_a;
			entry.word_b = word_b;
			entry.word_c = word_c;
			entry.length = 64'd0;
		end
	end

	// Key boundary and running length
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mid_key_q <= 1'b0;
			count_q   <= 64'd0;
		end else if (accept) begin
			mid_key_q <= !last;
			count_q   <= base_count + m64kh_pkg::BLOCK_BYTES;
		end
	end

endmodule

// ===== hdl/m64kh_queue.sv =====
// Small FIFO between the front and back ends.
`timescale 1ns / 1ps

module m64kh_queue #(
	parameter int DEPTH = 4
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   wr_en,
	input  m64kh_pkg::hash_entry_t wr_data,
	output logic                   full,
	input  logic                   rd_en,
	output m64kh_pkg::hash_entry_t rd_data,
	output logic                   empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	m64kh_pkg::hash_entry_t mem_q [0:DEPTH-1];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full    = (count_q == FULL_CNT);
	assign empty   = (count_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== hdl/m64kh_back.sv =====
// Back end: adds a block to the state, then one mix line per unstalled cycle.
`timescale 1ns / 1ps

module m64kh_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   q_empty,
	input  m64kh_pkg::hash_entry_t q_data,
	output logic                   q_pop,
	output logic                   empty,
	input  logic                   pop,
	output logic [63:0]            hash_value
);

	m64kh_pkg::back_state_t state_q, state_d;
	m64kh_pkg::lane_t       lane_q, lane_d;
	logic [3:0]  round_q, round_d;
	logic [63:0] a_q, b_q, c_q;
	logic [63:0] a_d, b_d, c_d;
	logic        last_q, last_d;
	logic        out_valid_q, out_valid_d;
	logic [63:0] hash_q, hash_d;
	logic [5:0]  sh;
	logic        final_round;
	logic        stall;

	assign empty      = !out_valid_q;
	assign hash_value = hash_q;

	assign sh          = m64kh_pkg::MIX_SHIFT[round_q];
	assign final_round = (round_q == 4'(m64kh_pkg::MIX_ROUNDS - 1));
	assign stall       = final_round && last_q && out_valid_q && !pop;

	// Sequencer, block add and mix line
	always_comb begin
		state_d     = state_q;
		lane_d      = lane_q;
		round_d     = round_q;
		a_d         = a_q;
		b_d         = b_q;
		c_d         = c_q;
		last_d      = last_q;
		hash_d      = hash_q;
		out_valid_d = out_valid_q && !pop;
		q_pop       = 1'b0;
		case (state_q)
			m64kh_pkg::BK_IDLE: begin
				if (!q_empty) begin
					q_pop   = 1'b1;
					a_d     = (q_data.first ? q_data.seed : a_q) + q_data.word_a;
					b_d     = (q_data.first ? q_data.seed : b_q) + q_data.word_b;
					c_d     = (q_data.first ? m64kh_pkg::GOLDEN_RATIO : c_q)
					          + q_data.word_c + q_data.length;
					last_d  = q_data.last;
					lane_d  = m64kh_pkg::LANE_A;
					round_d = 4'd0;
					state_d = m64kh_pkg::BK_MIX;
				end
			end
			m64kh_pkg::BK_MIX: begin
				if (!stall) begin
					case (lane_q)
						m64kh_pkg::LANE_A: begin
							a_d    = (a_q - b_q - c_q) ^ (c_q >> sh);
							lane_d = m64kh_pkg::LANE_B;
						end
						m64kh_pkg::LANE_B: begin
							b_d    = (b_q - c_q - a_q) ^ (a_q << sh);
							lane_d = m64kh_pkg::LANE_C;
						end
						m64kh_pkg::LANE_C: begin
							c_d    = (c_q - a_q - b_q) ^ (b_q >> sh);
							lane_d = m64kh_pkg::LANE_A;
						end
						default: begin
							lane_d = m64kh_pkg::LANE_A;
						end
					endcase
					round_d = final_round ? 4'd0 : round_q + 4'd1;
					if (final_round) begin
						state_d = m64kh_pkg::BK_IDLE;
						if (last_q) begin
							hash_d      = c_d;
							out_valid_d = 1'b1;
						end
					end
				end
			end
			default: begin
				state_d = m64kh_pkg::BK_IDLE;
			end
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= m64kh_pkg::BK_IDLE;
			lane_q      <= m64kh_pkg::LANE_A;
			round_q     <= 4'd0;
			out_valid_q <= 1'b0;
			last_q      <= 1'b0;
			a_q         <= 64'd0;
			b_q         <= 64'd0;
			c_q         <= 64'd0;
		end else begin
			state_q     <= state_d;
			lane_q      <= lane_d;
			round_q     <= round_d;
			out_valid_q <= out_valid_d;
			last_q      <= last_d;
			a_q         <= a_d;
			b_q         <= b_d;
			c_q         <= c_d;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q <= 64'd0;
		end else begin
			hash_q <= hash_d;
		end
	end

endmodule

// ===== hdl/mix64_key_hash_engine_unit.sv =====
// Top level of the streaming 64-bit key hash engine.
// Each item has its block added in the back end, then runs twelve mix lines,
// one per cycle while the back end is not stalled. The back end pops the next
// item only once the mix is done; with it idle, a last item's hash passes
// through the queue, the block add and the mix lines to the result ports.
// An unpopped hash holds a last item on its final mix line; the queue holds
// QUEUE_DEPTH items. Asynchronous reset clears the queue, key tracking and result.
`timescale 1ns / 1ps

module mix64_key_hash_engine_unit #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [63:0] word_a,
	input  logic [63:0] word_b,
	input  logic [63:0] word_c,
	input  logic [4:0]  tail_bytes,
	input  logic        last,
	input  logic [63:0] seed,
	output logic        empty,
	input  logic        pop,
	output logic [63:0] hash_value
);

	m64kh_pkg::hash_entry_t front_entry;
	m64kh_pkg::hash_entry_t q_data;
	logic accept;
	logic q_empty;
	logic q_pop;

	assign accept = push && !full;

	// Classify and mask incoming items
	m64kh_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.word_a     (word_a),
		.word_b     (word_b),
		.word_c     (word_c),
		.tail_bytes (tail_bytes),
		.last       (last),
		.seed       (seed),
		.entry      (front_entry)
	);

	// Decoupling queue
	m64kh_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (accept),
		.wr_data (front_entry),
		.full    (full),
		.rd_en   (q_pop),
		.rd_data (q_data),
		.empty   (q_empty)
	);

	// Mixing sequencer and result register
	m64kh_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (q_empty),
		.q_data     (q_data),
		.q_pop      (q_pop),
		.empty      (empty),
		.pop        (pop),
		.hash_value (hash_value)
	);

endmodule

// ===== tb/sv/mix64_key_hash_engine_unit_tb.sv =====
// Testbench for the 64-bit key hash engine: streamed random keys checked against a local hash model.
`timescale 1ns / 1ps

module mix64_key_hash_engine_unit_tb;

	localparam logic [63:0] GOLDEN        = 64'h9e3779b97f4a7c13;
	localparam int unsigned TAIL_MAX      = 23;
	localparam int unsigned BLOCK_LEN     = 24;
	localparam int unsigned ITEM_COUNT    = 1850;
	localparam int unsigned CYCLE_LIMIT   = 400000;
	localparam int unsigned SETTLE_CYCLES = 40;
	localparam int unsigned HOLD_CYCLES   = 300;
	localparam int          BOUNDARY_TAILS [8] = '{1, 7, 8, 9, 15, 16, 17, 22};

	typedef struct {
		logic [63:0] word_a;
		logic [63:0] word_b;
		logic [63:0] word_c;
		logic [4:0]  tail;
		logic        is_last;
		logic [63:0] seed;
	} key_item_t;

	// Running key hash and the queue of hashes still owed by the block
	class hash_scoreboard;
		bit [63:0]   st_a, st_b, st_c;
		bit [63:0]   key_len;
		bit          in_key;
		bit [63:0]   hash_q [$];
		int unsigned errors;

		function int unsigned pending();
			return hash_q.size();
		endfunction

		function bit [63:0] keep_low(bit [63:0] w, int unsigned n);
			if (n >= 8) return w;
			return w & ((64'd1 << (8 * n)) - 64'd1);
		endfunction

		// Twelve subtract/xor/shift lines over the three accumulators
		function void churn();
			st_a = (st_a - st_b - st_c) ^ (st_c >> 43);
			st_b = (st_b - st_c - st_a) ^ (st_a << 9);
			st_c = (st_c - st_a - st_b) ^ (st_b >> 8);
			st_a = (st_a - st_b - st_c) ^ (st_c >> 38);
			st_b = (st_b - st_c - st_a) ^ (st_a << 23);
			st_c = (st_c - st_a - st_b) ^ (st_b >> 5);
			st_a = (st_a - st_b - st_c) ^ (st_c >> 35);
			st_b = (st_b - st_c - st_a) ^ (st_a << 49);
			st_c = (st_c - st_a - st_b) ^ (st_b >> 11);
			st_a = (st_a - st_b - st_c) ^ (st_c >> 12);
			st_b = (st_b - st_c - st_a) ^ (st_a << 18);
			st_c = (st_c - st_a - st_b) ^ (st_b >> 22);
		endfunction

		function void note_item(bit [63:0] wa, bit [63:0] wb, bit [63:0] wc,
				bit [4:0] tb, bit lst, bit [63:0] sd);
			int unsigned n;
			// first item of a key loads the seed
			if (!in_key) begin
				st_a = sd;
				st_b = sd;
				st_c = GOLDEN;
				key_len = '0;
			end
			if (!lst) begin
				st_a += wa;
				st_b += wb;
				st_c += wc;
				churn();
				key_len += BLOCK_LEN;
				in_key = 1'b1;
				return;
			end
			// tail item: clamp count, mask unused bytes, c bytes go up one byte
			n = (tb > TAIL_MAX) ? TAIL_MAX : tb;
			key_len += n;
			st_c += key_len;
			st_a += keep_low(wa, n);
			st_b += keep_low(wb, (n > 8) ? n - 8 : 0);
			st_c += keep_low(wc, (n > 16) ? n - 16 : 0) << 8;
			churn();
			hash_q.push_back(st_c);
			in_key = 1'b0;
		endfunction

		function void check_result(logic [63:0] got);
			bit [63:0] want;
			if (hash_q.size() == 0) begin
				$display("%0t: hash %h arrived with none expected", $time, got);
				errors++;
				return;
			end
			want = hash_q.pop_front();
			if (got !== want) begin
				$display("%0t: hash_value mismatch: expected %h, actual %h", $time, want, got);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic [63:0] word_a = '0;
	logic [63:0] word_b = '0;
	logic [63:0] word_c = '0;
	logic [4:0]  tail_bytes = '0;
	logic        last = 1'b0;
	logic [63:0] seed = '0;
	logic        pop = 1'b0;
	logic        full;
	logic        empty;
	logic [63:0] hash_value;

	hash_scoreboard sb = new();
	int unsigned    sent = 0;
	int unsigned    cycles = 0;
	bit             tx_gaps = 1'b0;
	bit             rx_gaps = 1'b1;
	bit             hold_req = 1'b0;

	mix64_key_hash_engine_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.word_a     (word_a),
		.word_b     (word_b),
		.word_c     (word_c),
		.tail_bytes (tail_bytes),
		.last       (last),
		.seed       (seed),
		.empty      (empty),
		.pop        (pop),
		.hash_value (hash_value)
	);

	always #1 clk = ~clk;

	// Watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d hashes outstanding", $time, sb.pending());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Both handshakes sampled at the edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (push && !full)
				sb.note_item(word_a, word_b, word_c, tail_bytes, last, seed);
			if (pop && !empty)
				sb.check_result(hash_value);
		end
	end

	function automatic logic [63:0] pick_word();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			2: return 64'd1 << $urandom_range(0, 63);
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic key_item_t make_item(logic [63:0] wa, logic [63:0] wb, logic [63:0] wc,
			logic [4:0] tb, logic lst, logic [63:0] sd);
		key_item_t it;
		it.word_a  = wa;
		it.word_b  = wb;
		it.word_c  = wc;
		it.tail    = tb;
		it.is_last = lst;
		it.seed    = sd;
		return it;
	endfunction

	// Mostly legal tail counts on a last item, occasionally an oversized one
	function automatic key_item_t random_item(logic lst);
		logic [4:0] tb;
		if (lst && $urandom_range(0, 9) != 0)
			tb = 5'($urandom_range(0, TAIL_MAX));
		else
			tb = 5'($urandom_range(0, 31));
		return make_item(pick_word(), pick_word(), pick_word(), tb, lst, pick_word());
	endfunction

	// Offer one item until taken, then maybe idle a while
	task automatic send_item(input key_item_t it);
		push       <= 1'b1;
		word_a     <= it.word_a;
		word_b     <= it.word_b;
		word_c     <= it.word_c;
		tail_bytes <= it.tail;
		last       <= it.is_last;
		seed       <= it.seed;
		@(posedge clk);
		while (full) @(posedge clk);
		sent++;
		if (tx_gaps && $urandom_range(0, 5) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
	endtask

	// Mostly short keys, a few long ones
	task automatic send_random_key();
		int unsigned blocks;
		blocks = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 3) : $urandom_range(4, 12);
		repeat (blocks) send_item(random_item(1'b0));
		send_item(random_item(1'b1));
	endtask

	// One edge first so the item taken at the last edge is already noted
	task automatic drain_hashes();
		push <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
	endtask

	// Result side: pop runs, random stalls, and one long hold on request
	initial begin
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				pop <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (rx_gaps && $urandom_range(0, 4) == 0) begin
				pop <= 1'b0;
				repeat ($urandom_range(1, 13)) @(posedge clk);
			end else begin
				pop <= 1'b1;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end
		end
	end

	// Stimulus
	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty keys, full masking, full tail, oversized tail counts
		send_item(make_item('0, '0, '0, 5'd0, 1'b1, '0));
		send_item(make_item('1, '1, '1, 5'd0, 1'b1, '1));
		send_item(make_item('1, '1, '1, 5'd23, 1'b1, '1));
		send_item(make_item('1, '1, '1, 5'd31, 1'b1, '0));
		send_item(make_item(pick_word(), pick_word(), pick_word(), 5'd24, 1'b1, pick_word()));
		// tail counts on either side of each word boundary
		foreach (BOUNDARY_TAILS[i])
			send_item(make_item('1, {$urandom, $urandom}, '1, 5'(BOUNDARY_TAILS[i]), 1'b1,
				{$urandom, $urandom}));
		// multi-block key; seed and tail count ignored mid-key
		send_item(make_item({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
			5'd0, 1'b0, 64'h0123456789abcdef));
		send_item(make_item({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
			5'd13, 1'b0, '1));
		send_item(make_item('1, '1, '1, 5'd0, 1'b0, '0));
		send_item(make_item({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
			5'd20, 1'b1, '1));
		// all-zero block then an empty tail
		send_item(make_item('0, '0, '0, 5'd0, 1'b0, '0));
		send_item(make_item('0, '0, '0, 5'd0, 1'b1, '0));

		// random keys with idling on both sides
		tx_gaps = 1'b1;
		while (sent < 700) send_random_key();

		// receiver holds off while short keys keep coming, so the block backs up
		tx_gaps = 1'b0;
		hold_req = 1'b1;
		repeat (30) send_item(random_item(1'b1));
		drain_hashes();

		tx_gaps = 1'b1;
		while (sent < 1500) send_random_key();
		drain_hashes();

		// closing stretch at full rate
		tx_gaps = 1'b0;
		rx_gaps = 1'b0;
		while (sent < ITEM_COUNT) send_random_key();
		drain_hashes();
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (sb.errors == 0 && sb.pending() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
